// File: hdl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg: shared types and constants of the alpha over blend unit
// fixed point alpha terms use 16 fractional bits, 1.0 = 65536
// ----------------------------------------------------------------------------
package aob_pkg;

  localparam int unsigned NumStages = 12;
  localparam int unsigned CovStages = 6;   // stages inside aob_alpha
  localparam int unsigned DivSteps  = 4;   // divide stages, two quotient bits each

  localparam logic [16:0] OneQ16 = 17'd65536;

  // reciprocal of 65025 scaled by 2^48, exact for dividends below 2^32
  localparam logic [32:0] RecipOpq = 33'(((64'd1 << 48) / 64'd65025) + 64'd1);
  localparam logic [15:0] RecipOpqHi = RecipOpq[32:17];
  localparam logic [16:0] RecipOpqLo = RecipOpq[16:0];
  // rounding offset of the source alpha scaling, already multiplied up
  localparam logic [65:0] OpqRoundTerm = 66'(RecipOpq) * 66'd32512;

  // reciprocal of 255 scaled by 2^32, exact for dividends below 2^24
  localparam logic [24:0] Recip255 = 25'(((64'd1 << 32) / 64'd255) + 64'd1);

  typedef struct packed {
    logic [2:0][7:0] src;  // red, green, blue from index 0
    logic [2:0][7:0] dst;
  } rgb_pair_t;

  typedef struct packed {
    logic [16:0] s;
    logic [16:0] d;
    logic [16:0] c;
    logic [7:0]  alpha;
  } cov_t;

endpackage

// File: hdl/aob_alpha.sv
// ----------------------------------------------------------------------------
// aob_alpha: coverage pipeline
// scaled source alpha, destination weight, combined coverage and out alpha
// ----------------------------------------------------------------------------
module aob_alpha import aob_pkg::*; (
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  logic [7:0]           opacity_i,
  input  logic [7:0]           src_alpha_i,
  input  logic [7:0]           dst_alpha_i,
  input  rgb_pair_t            rgb_i,
  output cov_t                 cov_o,
  output rgb_pair_t            rgb_o
);

  rgb_pair_t   rgb_q [CovStages];
  logic [7:0]  da_q  [CovStages-1];
  logic [15:0] p_q;
  logic [31:0] ph_q;
  logic [32:0] pl_q;
  logic [16:0] s2_q, s3_q, s4_q;
  logic [23:0] t_q;
  logic [16:0] d_q;
  cov_t        cov_q;

  logic [65:0] sum_w;
  logic [24:0] t_w;
  logic [48:0] u_w;
  logic [16:0] c_w;
  logic [24:0] a_w;

  assign sum_w = ((66'({ph_q, 17'd0}) + 66'(pl_q)) << 16) + OpqRoundTerm;
  assign t_w   = 25'(OneQ16 - s3_q) * 25'(da_q[3]);
  assign u_w   = 49'(25'(t_q) + 25'd127) * 49'(Recip255);
  assign c_w   = cov_q.s + d_q;
  assign a_w   = 25'(c_w) * 25'd255 + 25'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q      <= src_alpha_i * opacity_i;
      rgb_q[0] <= rgb_i;
      da_q[0]  <= dst_alpha_i;
    end
    if (en_i[1]) begin
      ph_q     <= p_q * RecipOpqHi;
      pl_q     <= 33'(p_q) * 33'(RecipOpqLo);
      rgb_q[1] <= rgb_q[0];
      da_q[1]  <= da_q[0];
    end
    if (en_i[2]) begin
      s2_q     <= sum_w[64:48];
      rgb_q[2] <= rgb_q[1];
      da_q[2]  <= da_q[1];
    end
    if (en_i[3]) begin
      s3_q     <= s2_q;
      rgb_q[3] <= rgb_q[2];
      da_q[3]  <= da_q[2];
    end
    if (en_i[4]) begin
      t_q      <= t_w[23:0];
      s4_q     <= s3_q;
      rgb_q[4] <= rgb_q[3];
    end
    if (en_i[5]) begin
      d_q      <= u_w[48:32];
      rgb_q[5] <= rgb_q[4];
    end
  end

  // coverage word out of the last stage
  always_ff @(posedge clk_i) begin
    if (en_i[CovStages-1]) begin
      cov_q.s     <= s4_q;
      cov_q.d     <= u_w[48:32];
      cov_q.c     <= '0;
      cov_q.alpha <= '0;
    end
  end

  // c and alpha are combinational, formed from the registered s and d
  cov_t cov_w;
  always_comb begin
    cov_w       = cov_q;
    cov_w.d     = d_q;
    cov_w.c     = c_w;
    cov_w.alpha = a_w[23:16];
  end

  assign cov_o = cov_w;
  assign rgb_o = rgb_q[5];

endmodule

// File: hdl/aob_div.sv
// ----------------------------------------------------------------------------
// aob_div: one colour lane
// weighted sum of source and destination, then restoring divide by coverage
// ----------------------------------------------------------------------------
module aob_div import aob_pkg::*; (
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  logic [7:0]           cs_i,
  input  logic [7:0]           cd_i,
  input  logic [16:0]          s_i,
  input  logic [16:0]          d_i,
  input  logic [16:0]          c_i,
  output logic [7:0]           q_o
);

  localparam int unsigned Base = CovStages;

  logic [24:0] pd_q, ps_q;
  logic [16:0] c_q;
  logic [25:0] rem_q [DivSteps+1];
  logic [7:0]  quo_q [DivSteps+1];
  logic [17:0] den_q [DivSteps+1];
  logic [25:0] rem_d [DivSteps+1];
  logic [7:0]  quo_d [DivSteps+1];

  always_comb begin
    logic [25:0] r;
    logic [7:0]  q;
    logic [25:0] sh;
    int          i;
    rem_d[0] = 26'({1'b0, pd_q} + {1'b0, ps_q}) * 26'd2 + 26'(c_q);
    quo_d[0] = '0;
    for (int g = 0; g < DivSteps; g++) begin
      r = rem_q[g];
      q = quo_q[g];
      for (int b = 0; b < 2; b++) begin
        i  = 7 - 2 * g - b;
        sh = 26'(den_q[g]) << i;
        if (r >= sh) begin
          r       = r - sh;
          q[3'(i)] = 1'b1;
        end
      end
      rem_d[g+1] = r;
      // zero coverage gives black
      quo_d[g+1] = (g == DivSteps - 1 && den_q[g] == '0) ? 8'd0 : q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[Base]) begin
      pd_q <= 25'(cd_i) * 25'(d_i);
      ps_q <= 25'(cs_i) * 25'(s_i);
      c_q  <= c_i;
    end
    if (en_i[Base+1]) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      den_q[0] <= {c_q, 1'b0};
    end
    for (int g = 0; g < DivSteps; g++) begin
      if (en_i[Base+2+g]) begin
        rem_q[g+1] <= rem_d[g+1];
        quo_q[g+1] <= quo_d[g+1];
        den_q[g+1] <= den_q[g];
      end
    end
  end

  assign q_o = quo_q[DivSteps];

endmodule

// File: hdl/argb_alpha_over_blend_unit.sv
// ----------------------------------------------------------------------------
// argb_alpha_over_blend_unit: source over compositing of two ARGB pixels
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[63:0] src argb, dst argb
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[31:0] out argb
//  cfg       in   cfg_we_i                       cfg_wdata_i[7:0] layer opacity
//
//  one pixel per cycle sustained while m_axis_tready stays high; the pipeline depth
//  is set by the reciprocal multiplies and the 8-bit restoring divide of each
//  colour, two quotient bits per stage
//  reset empties the pipeline and sets opacity to 255
//  a stall holds only the stages that are full, bubbles close up behind it
// ----------------------------------------------------------------------------
module argb_alpha_over_blend_unit import aob_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // src_alpha, src_red, src_green, src_blue, dst_alpha, dst_red, dst_green, dst_blue
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_alpha, out_red, out_green, out_blue
  output logic [31:0] m_axis_tdata
);

  logic [7:0]           opacity_q;
  logic [NumStages-1:0] v_q, en;
  rgb_pair_t            rgb_in, rgb_mid;
  cov_t                 cov;
  logic [7:0]           alpha_q [NumStages-CovStages];
  logic [2:0][7:0]      q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= 8'd255;
    end else if (cfg_we_i) begin
      opacity_q <= cfg_wdata_i;
    end
  end

  // a stage may load when it is empty or the next one loads
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign rgb_in.src = {s_axis_tdata[31:24], s_axis_tdata[23:16], s_axis_tdata[15:8]};
  assign rgb_in.dst = {s_axis_tdata[63:56], s_axis_tdata[55:48], s_axis_tdata[47:40]};

  aob_alpha u_alpha (
    .clk_i       (clk_i),
    .en_i        (en),
    .opacity_i   (opacity_q),
    .src_alpha_i (s_axis_tdata[7:0]),
    .dst_alpha_i (s_axis_tdata[39:32]),
    .rgb_i       (rgb_in),
    .cov_o       (cov),
    .rgb_o       (rgb_mid)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    aob_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .cs_i  (rgb_mid.src[ch]),
      .cd_i  (rgb_mid.dst[ch]),
      .s_i   (cov.s),
      .d_i   (cov.d),
      .c_i   (cov.c),
      .q_o   (q[ch])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[CovStages]) begin
      alpha_q[0] <= cov.alpha;
    end
    for (int k = 1; k < NumStages - CovStages; k++) begin
      if (en[CovStages+k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NumStages-1];
  assign m_axis_tdata  = {q[2], q[1], q[0], alpha_q[NumStages-CovStages-1]};

endmodule

// File: hdl/aob_checker.sv
// ----------------------------------------------------------------------------
// aob_checker: port level checks of the blend unit
// handshake rules and the stall behaviour of the pipeline
// ----------------------------------------------------------------------------
module aob_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // stalled beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // stalled beat keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with output stage empty");

  // a draining output never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");

  // nothing comes out right after reset before any beat could pass
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid straight out of reset");

endmodule

bind argb_alpha_over_blend_unit aob_checker u_aob_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
